>>> hw/rtl/terq_pkg.sv
// ----------------------------------------------------------------------------
// terq_pkg
// Types and constants shared by the timed event release queue.
// ----------------------------------------------------------------------------
package terq_pkg;

   localparam int TIME_WIDTH      = 63;
   localparam int HANDLE_WIDTH    = 16;
   localparam int LENGTH_WIDTH    = 16;
   localparam int MARGIN_WIDTH    = 16;
   localparam int COUNT_WIDTH     = 5;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int CSR_ADDR_WIDTH  = 3;
   localparam int CSR_INDEX_WIDTH = CSR_ADDR_WIDTH - 2;

   localparam logic [MARGIN_WIDTH-1:0]    MARGIN_RESET     = 16'd500;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_EARLY_MARGIN = 1'b0;

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_TICK   = 2'd1;
   localparam logic [1:0] MODE_CLEAR  = 2'd2;

   localparam logic [1:0] STATUS_DONE = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_IDLE = 2'd2;

   typedef struct packed {
      logic [1:0]              mode;
      logic [TIME_WIDTH-1:0]   event_time;
      logic [HANDLE_WIDTH-1:0] payload_handle;
      logic [LENGTH_WIDTH-1:0] payload_length;
   } req_type;

   typedef struct packed {
      logic [1:0]              status;
      logic                    released;
      logic [HANDLE_WIDTH-1:0] released_handle;
      logic [LENGTH_WIDTH-1:0] released_length;
      logic [TIME_WIDTH-1:0]   released_time;
      logic                    queue_empty;
      logic [COUNT_WIDTH-1:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      logic [TIME_WIDTH-1:0]   event_time;
      logic [HANDLE_WIDTH-1:0] handle;
      logic [LENGTH_WIDTH-1:0] length;
   } entry_type;

endpackage

>>> hw/rtl/terq_ram.sv
// ----------------------------------------------------------------------------
// terq_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module terq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/timed_event_release_queue.sv
// ----------------------------------------------------------------------------
// timed_event_release_queue
// Bounded queue of timed transmit descriptors, sorted by release time and
// held as a ring in one RAM; a sequencer walks it, reading one slot at a time.
// ----------------------------------------------------------------------------
//   channel   ports                         flow
//   request   start, busy, req_data         in, taken when start & !busy
//   result    rsp_valid, rsp_data           out, one-cycle strobe
//   csr       psel..pready, paddr, pwdata   APB, early_margin at 0x0
//
// Clear, full or empty insert, empty tick, unused mode: result in the next cycle.
// Tick on a held head: one RAM read in idle, then the margin compare in S_TICK.
// Other insert: entries later than the new one shift up a slot in S_INSERT,
// then the new entry is written; at most one RAM read and one write each cycle.
// Synchronous reset empties the queue and loads early_margin with 500.
// The receiver cannot stall; busy is low again in the result cycle.
// ----------------------------------------------------------------------------
module timed_event_release_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  terq_pkg::req_type                       req_data,
   output logic                                    rsp_valid,
   output terq_pkg::rsp_type                       rsp_data,
   input  logic                                    psel,
   input  logic                                    penable,
   input  logic                                    pwrite,
   input  logic [terq_pkg::CSR_ADDR_WIDTH-1:0]     paddr,
   input  logic [terq_pkg::CSR_DATA_WIDTH-1:0]     pwdata,
   output logic [terq_pkg::CSR_DATA_WIDTH-1:0]     prdata,
   output logic                                    pready
);

   import terq_pkg::*;

   localparam int IW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [IW:0]   DEPTH_W = (IW + 1)'(QUEUE_DEPTH);
   localparam logic [CW-1:0] FULL_W  = CW'(QUEUE_DEPTH);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_INSERT = 4'b0010,
      S_PUT    = 4'b0100,
      S_TICK   = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   logic [IW-1:0]          head_ff, head_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [IW-1:0]          k_ff, k_in;
   req_type                req_ff, req_in;
   logic [MARGIN_WIDTH-1:0] margin_ff, margin_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   wr_en;
   logic [IW-1:0]          wr_addr;
   entry_type              wr_data;
   logic [IW-1:0]          rd_addr;
   entry_type              rd_data;
   entry_type              new_entry;
   logic                   csr_write;
   logic                   due;

   function automatic logic [IW-1:0] slot_addr(input logic [IW-1:0] base,
                                                input logic [IW-1:0] offset);
      logic [IW:0] sum;
      sum = {1'b0, base} + {1'b0, offset};
      if (sum >= DEPTH_W) begin
         sum = sum - DEPTH_W;
      end
      return sum[IW-1:0];
   endfunction

   terq_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // csr port
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;
   assign prdata    = (paddr[CSR_ADDR_WIDTH-1:2] == REG_EARLY_MARGIN)
                      ? CSR_DATA_WIDTH'(margin_ff) : '0;

   always_comb begin
      margin_in = margin_ff;
      if (csr_write && paddr[CSR_ADDR_WIDTH-1:2] == REG_EARLY_MARGIN) begin
         margin_in = pwdata[MARGIN_WIDTH-1:0];
      end
   end

   assign new_entry.event_time = req_ff.event_time;
   assign new_entry.handle     = req_ff.payload_handle;
   assign new_entry.length     = req_ff.payload_length;

   assign due = ({1'b0, req_ff.event_time} + 64'(margin_ff))
                >= {1'b0, rd_data.event_time};

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      k_in         = k_ff;
      req_in       = req_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      rsp_in.status = STATUS_DONE;
      wr_en        = 1'b0;
      wr_addr      = head_ff;
      wr_data      = new_entry;
      rd_addr      = head_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_data;
               unique case (req_data.mode)
                  MODE_INSERT: begin
                     if (count_ff == FULL_W) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = STATUS_FULL;
                     end else if (count_ff == '0) begin
                        wr_en                  = 1'b1;
                        wr_data.event_time     = req_data.event_time;
                        wr_data.handle         = req_data.payload_handle;
                        wr_data.length         = req_data.payload_length;
                        count_in               = CW'(1);
                        rsp_valid_in           = 1'b1;
                     end else begin
                        k_in     = count_ff[IW-1:0];
                        rd_addr  = slot_addr(head_ff, count_ff[IW-1:0] - IW'(1));
                        state_in = S_INSERT;
                     end
                  end
                  MODE_TICK: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = STATUS_IDLE;
                     end else begin
                        state_in = S_TICK;
                     end
                  end
                  MODE_CLEAR: begin
                     count_in     = '0;
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_INSERT: begin
            wr_en   = 1'b1;
            wr_addr = slot_addr(head_ff, k_ff);
            if (rd_data.event_time > req_ff.event_time) begin
               wr_data = rd_data;
               k_in    = k_ff - IW'(1);
               rd_addr = slot_addr(head_ff, k_ff - IW'(2));
               if (k_ff == IW'(1)) begin
                  state_in = S_PUT;
               end
            end else begin
               count_in     = count_ff + CW'(1);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_PUT: begin
            wr_en        = 1'b1;
            wr_addr      = head_ff;
            count_in     = count_ff + CW'(1);
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_TICK: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            if (due) begin
               rsp_in.released        = 1'b1;
               rsp_in.released_handle = rd_data.handle;
               rsp_in.released_length = rd_data.length;
               rsp_in.released_time   = rd_data.event_time;
               head_in                = slot_addr(head_ff, IW'(1));
               count_in               = count_ff - CW'(1);
            end else begin
               rsp_in.status = STATUS_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_in.entry_count = COUNT_WIDTH'(count_in);
      rsp_in.queue_empty = (count_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         margin_ff    <= MARGIN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         margin_ff    <= margin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff   <= k_in;
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> dv/release_queue_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// release_queue_checker
// Watches the request, result and register ports of the timed event release
// queue, keeps a sorted shadow of the held descriptors and the early margin,
// and checks every result field against the predicted outcome.
// ----------------------------------------------------------------------------
module release_queue_checker #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  terq_pkg::req_type                   req_data,
   input  logic                                rsp_valid,
   input  terq_pkg::rsp_type                   rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic                                pready,
   input  logic [terq_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [terq_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output int                                  fail_count,
   output int                                  pending,
   output int                                  transfer_count,
   output int                                  release_count,
   output int                                  reject_count
);

   import terq_pkg::*;

   entry_type               shadow_slot [QUEUE_DEPTH];
   int                      shadow_count;
   logic [MARGIN_WIDTH-1:0] shadow_margin;
   rsp_type                 awaited_rsp [$];

   function automatic rsp_type queue_outcome(input req_type r);
      rsp_type o;
      int      pos;
      int      k;
      o = '0;
      o.status = STATUS_DONE;
      case (r.mode)
         MODE_INSERT: begin
            if (shadow_count >= QUEUE_DEPTH) begin
               o.status = STATUS_FULL;
            end else begin
               pos = 0;
               while (pos < shadow_count && shadow_slot[pos].event_time <= r.event_time)
                  pos++;
               for (k = shadow_count; k > pos; k--)
                  shadow_slot[k] = shadow_slot[k-1];
               shadow_slot[pos] = '{event_time: r.event_time,
                                    handle:     r.payload_handle,
                                    length:     r.payload_length};
               shadow_count++;
            end
         end
         MODE_TICK: begin
            if (shadow_count > 0 &&
                ({1'b0, r.event_time} + {48'd0, shadow_margin}) >=
                {1'b0, shadow_slot[0].event_time}) begin
               o.released        = 1'b1;
               o.released_handle = shadow_slot[0].handle;
               o.released_length = shadow_slot[0].length;
               o.released_time   = shadow_slot[0].event_time;
               for (k = 1; k < shadow_count; k++)
                  shadow_slot[k-1] = shadow_slot[k];
               shadow_count--;
            end else begin
               o.status = STATUS_IDLE;
            end
         end
         MODE_CLEAR: shadow_count = 0;
         default: ;
      endcase
      o.queue_empty = (shadow_count == 0);
      o.entry_count = COUNT_WIDTH'(shadow_count);
      return o;
   endfunction

   task automatic check_field(input string name, input logic [63:0] e, input logic [63:0] a);
      if (e !== a) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
      end
   endtask

   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (reset) begin
         awaited_rsp.delete();
         shadow_count   = 0;
         shadow_margin  = MARGIN_RESET;
         fail_count     = 0;
         transfer_count = 0;
         release_count  = 0;
         reject_count   = 0;
      end else begin
         if (rsp_valid) begin
            if (awaited_rsp.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result, expected none, actual %0h", $time, rsp_data);
            end else begin
               exp_rsp = awaited_rsp.pop_front();
               check_field("status", 64'(exp_rsp.status), 64'(rsp_data.status));
               check_field("released", 64'(exp_rsp.released), 64'(rsp_data.released));
               check_field("released_handle", 64'(exp_rsp.released_handle),
                           64'(rsp_data.released_handle));
               check_field("released_length", 64'(exp_rsp.released_length),
                           64'(rsp_data.released_length));
               check_field("released_time", 64'(exp_rsp.released_time),
                           64'(rsp_data.released_time));
               check_field("queue_empty", 64'(exp_rsp.queue_empty),
                           64'(rsp_data.queue_empty));
               check_field("entry_count", 64'(exp_rsp.entry_count),
                           64'(rsp_data.entry_count));
            end
         end
         if (start && !busy) begin
            exp_rsp = queue_outcome(req_data);
            awaited_rsp.push_back(exp_rsp);
            transfer_count++;
            if (exp_rsp.released)
               release_count++;
            if (exp_rsp.status == STATUS_FULL)
               reject_count++;
         end
         if (psel && penable && pwrite && pready &&
             paddr[CSR_ADDR_WIDTH-1:2] == REG_EARLY_MARGIN)
            shadow_margin = pwdata[MARGIN_WIDTH-1:0];
      end
      pending = awaited_rsp.size();
   end

endmodule

>>> dv/tb_timed_event_release_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timed_event_release_queue
// Drives descriptor inserts, time ticks and clears into the release queue
// under several early margins, with random gaps between transfers, and
// reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_timed_event_release_queue;
   import terq_pkg::*;

   localparam int                         QUEUE_DEPTH = 16;
   localparam int                         PHASES      = 6;
   localparam int                         PHASE_ITEMS = 125;
   localparam logic [1:0]                 MODE_UNUSED = 2'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_UNUSED  = 1'b1;
   localparam logic [TIME_WIDTH-1:0]      TIME_MAX    = '1;

   logic                      clock   = 1'b0;
   logic                      reset   = 1'b1;
   logic                      start   = 1'b0;
   req_type                   req_data = '0;
   logic                      busy;
   logic                      rsp_valid;
   rsp_type                   rsp_data;
   logic                      psel    = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite  = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] paddr   = '0;
   logic [CSR_DATA_WIDTH-1:0] pwdata  = '0;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic                      pready;

   int fail_count, pending, transfer_count, release_count, reject_count;

   logic [TIME_WIDTH-1:0]   now;
   logic [TIME_WIDTH-1:0]   last_insert;
   logic [MARGIN_WIDTH-1:0] margin_now;
   bit                      no_gaps;
   int                      items_sent;

   always #4 clock = ~clock;

   timed_event_release_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (
      .clock, .reset, .start, .busy, .req_data, .rsp_valid, .rsp_data,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   release_queue_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_checker (
      .clock, .reset, .start, .busy, .req_data, .rsp_valid, .rsp_data,
      .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
      .fail_count, .pending, .transfer_count, .release_count, .reject_count
   );

   function automatic logic [TIME_WIDTH-1:0] rand_time();
      return TIME_WIDTH'({$urandom, $urandom});
   endfunction

   // start stays high when the next transfer follows without a gap
   task automatic send(input logic [1:0] mode, input logic [TIME_WIDTH-1:0] t,
                       input logic [HANDLE_WIDTH-1:0] h, input logic [LENGTH_WIDTH-1:0] l);
      req_type r;
      int      gap;
      bit      ok;
      gap = no_gaps ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      r.mode           = mode;
      r.event_time     = t;
      r.payload_handle = h;
      r.payload_length = l;
      start    <= 1'b1;
      req_data <= r;
      do begin
         @(negedge clock);
         ok = !busy;
         @(posedge clock);
      end while (!ok);
      if (mode != MODE_UNUSED)
         items_sent++;
   endtask

   task automatic insert(input logic [TIME_WIDTH-1:0] t);
      send(MODE_INSERT, t, HANDLE_WIDTH'($urandom), LENGTH_WIDTH'($urandom));
      last_insert = t;
   endtask

   task automatic tick(input logic [TIME_WIDTH-1:0] t);
      send(MODE_TICK, t, HANDLE_WIDTH'($urandom), LENGTH_WIDTH'($urandom));
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      do @(negedge clock); while (pending != 0 || busy);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      bit ok;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do begin
         @(negedge clock);
         ok = pready;
         @(posedge clock);
      end while (!ok);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic fill_burst();
      int n;
      n = $urandom_range(14, 20);
      repeat (n) insert(now + TIME_WIDTH'(50 * $urandom_range(0, 6)));
      n = $urandom_range(2, 10);
      repeat (n) begin
         now += TIME_WIDTH'(100);
         tick(now);
      end
   endtask

   task automatic run_sequence();
      int                    kind;
      int                    n;
      logic [TIME_WIDTH-1:0] t;
      kind    = $urandom_range(0, 9);
      no_gaps = ($urandom_range(0, 3) == 0);
      case (kind)
         5: fill_burst();
         6: begin
            // release exactly at the margin boundary, one unit early first
            t = now + TIME_WIDTH'(margin_now) + TIME_WIDTH'(1 + $urandom_range(0, 1000));
            send(MODE_CLEAR, rand_time(), HANDLE_WIDTH'($urandom), LENGTH_WIDTH'($urandom));
            insert(t);
            tick(t - TIME_WIDTH'(margin_now) - TIME_WIDTH'(1));
            tick(t - TIME_WIDTH'(margin_now));
            now = t - TIME_WIDTH'(margin_now);
         end
         7: send(MODE_CLEAR, rand_time(), HANDLE_WIDTH'($urandom), LENGTH_WIDTH'($urandom));
         8, 9: begin
            n = $urandom_range(1, 6);
            repeat (n)
               send(2'($urandom_range(0, 3)), rand_time(),
                    HANDLE_WIDTH'($urandom), LENGTH_WIDTH'($urandom));
         end
         default: begin
            n = $urandom_range(4, 24);
            repeat (n) begin
               if ($urandom_range(0, 9) < 5) begin
                  if ($urandom_range(0, 5) == 0)
                     insert(last_insert);
                  else
                     insert(now + TIME_WIDTH'($urandom_range(0, 4000)));
               end else begin
                  now += TIME_WIDTH'($urandom_range(0, 800));
                  tick(now);
               end
            end
         end
      endcase
   endtask

   initial begin
      #2000000;
      $display("timed_event_release_queue test failed");
      $finish;
   end

   initial begin
      no_gaps     = 1'b0;
      items_sent  = 0;
      margin_now  = MARGIN_RESET;
      now         = TIME_WIDTH'($urandom_range(0, 1000000));
      last_insert = now;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty tick, ties, head insert, extremes, unused mode, clear
      tick('0);
      send(MODE_INSERT, 1000, 16'h0000, 16'h0000);
      send(MODE_INSERT, 1000, 16'hFFFF, 16'hFFFF);
      send(MODE_INSERT, 0, 16'h0001, 16'h0002);
      send(MODE_INSERT, TIME_MAX, 16'hA5A5, 16'h5A5A);
      send(MODE_UNUSED, TIME_MAX, 16'hFFFF, 16'hFFFF);
      tick('0);
      tick(499);
      tick(500);
      tick(500);
      tick(TIME_MAX - 500);
      tick(TIME_MAX);
      send(MODE_INSERT, TIME_MAX, 16'h5A5A, 16'hA5A5);
      tick(TIME_MAX);
      insert(7);
      insert(3);
      send(MODE_CLEAR, TIME_MAX, 16'hFFFF, 16'hFFFF);
      tick(TIME_MAX);
      fill_burst();

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            wait_idle();
            case (phase)
               1:       margin_now = '0;
               2:       margin_now = '1;
               4:       margin_now = MARGIN_WIDTH'($urandom_range(0, 255));
               default: margin_now = MARGIN_WIDTH'($urandom);
            endcase
            csr_write(REG_EARLY_MARGIN, {16'($urandom), margin_now});
            if (phase == 2)
               csr_write(REG_UNUSED, $urandom);
            if (phase == 2) begin
               // no wrap of the margin sum at the top of the time range
               send(MODE_CLEAR, '0, '0, '0);
               insert(TIME_MAX);
               tick(TIME_MAX);
               insert(TIME_WIDTH'(margin_now));
               tick('0);
            end
         end
         while (items_sent < (phase + 1) * PHASE_ITEMS)
            run_sequence();
      end

      start <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (25) @(posedge clock);
      @(negedge clock);
      $display("Covered %0d transfers: %0d releases, %0d full rejects, %0d margin settings.",
               transfer_count, release_count, reject_count, PHASES);
      if (fail_count == 0) begin
         $display("timed_event_release_queue test passed");
      end else begin
         $display("%0d mismatches found", fail_count);
         $display("timed_event_release_queue test failed");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/terq_pkg.sv
hw/rtl/terq_ram.sv
hw/rtl/timed_event_release_queue.sv
dv/release_queue_checker.sv
dv/tb_timed_event_release_queue.sv
